### design/piecewise_linear_resampler_unit_defines.svh
// Assertion macros shared by the resampler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PIECEWISE_LINEAR_RESAMPLER_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_RESAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define PLR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/plr_pkg.sv
// Types and constants of the piecewise linear resampler.
// No dependencies; used by the interfaces, the divider and the resampler top.
package plr_pkg;

   localparam int DATA_W = 32;

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_APPEND = 2'd1;
   localparam cmd_type CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } point_type;

   localparam int POINT_W = $bits(point_type);

endpackage

### design/plr_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on plr_pkg.
interface plr_req_if;
   import plr_pkg::*;

   logic                     valid;
   logic                     ready;
   cmd_type                  cmd;
   logic signed [DATA_W-1:0] point_x;
   logic signed [DATA_W-1:0] point_y;
   logic signed [DATA_W-1:0] query_x;

   modport source (output valid, output cmd, output point_x, output point_y,
                   output query_x, input ready);
   modport sink   (input valid, input cmd, input point_x, input point_y,
                   input query_x, output ready);
endinterface

interface plr_rsp_if;
   import plr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     below_range;
   logic                     no_table;

   modport source (output valid, output value, output below_range,
                   output no_table, input ready);
   modport sink   (input valid, input value, input below_range,
                   input no_table, output ready);
endinterface

### design/plr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module plr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/plr_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit DATA_W bits.
// Depends on plr_pkg and the assertion macro header.
module plr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [2*plr_pkg::DATA_W-1:0] dividend,
   input  logic [plr_pkg::DATA_W-1:0]   divisor,
   output logic                         done,
   output logic [plr_pkg::DATA_W-1:0]   quotient
);
   import plr_pkg::*;

   `include "piecewise_linear_resampler_unit_defines.svh"

   localparam int STEP_W = $clog2(DATA_W + 1);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [DATA_W-1:0] div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   trial;
   logic              fits;

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, lo_ff[DATA_W-1]};
      fits    = trial >= {1'b0, div_ff};
      if (start) begin
         rem_in  = dividend[2*DATA_W-1:DATA_W];
         lo_in   = dividend[DATA_W-1:0];
         div_in  = divisor;
         step_in = STEP_W'(DATA_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DATA_W'(trial - {1'b0, div_ff}) : trial[DATA_W-1:0];
         lo_in   = {lo_ff[DATA_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      div_ff <= div_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = lo_ff;

   `PLR_ASSERT_IMPLY(a_start_idle, clock, reset, start, !busy_ff, "divider restarted while busy")
   `PLR_ASSERT_IMPLY(a_rem_bound, clock, reset, busy_ff, rem_ff < div_ff, "remainder not below divisor")
   `PLR_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "done held longer than one cycle")

endmodule

### design/piecewise_linear_resampler_unit.sv
// Piecewise linear resampler. Clear and append items complete on acceptance in the idle state. A
// query result comes without a memory read for an empty table, after the first breakpoint read when
// below range or with one breakpoint, after the scan when clamped, and after the scan, multiply and
// divider when interpolated, the scan stepping over segments with one memory read each. One item is
// in work at a time: the next is taken the cycle after the result is registered.
// Synchronous reset empties the table and rewinds the segment pointer; memory is not cleared.
module piecewise_linear_resampler_unit #(
   parameter int MAX_POINTS = 256
) (
   input logic      clock,
   input logic      reset,
   plr_req_if.sink   req_chan,
   plr_rsp_if.source rsp_chan
);
   import plr_pkg::*;

   `include "piecewise_linear_resampler_unit_defines.svh"

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_LEFT, S_SCAN, S_MUL, S_START, S_DIV, S_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           seg_ff, seg_in;
   logic signed [DATA_W-1:0]   qx_ff, qx_in;
   logic signed [DATA_W-1:0]   xl_ff, xl_in;
   logic signed [DATA_W-1:0]   yl_ff, yl_in;
   logic [DATA_W-1:0]          span_ff, span_in;
   logic [DATA_W-1:0]          off_ff, off_in;
   logic [DATA_W-1:0]          mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [2*DATA_W-1:0]        prod_ff, prod_in;
   logic signed [DATA_W-1:0]   res_ff, res_in;
   logic                       below_ff, below_in;
   logic                       none_ff, none_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                       rsp_below_ff, rsp_below_in;
   logic                       rsp_none_ff, rsp_none_in;

   logic                       ram_we;
   logic [IDX_W-1:0]           ram_raddr;
   point_type                  ram_wdata;
   point_type                  rd;
   logic [POINT_W-1:0]         ram_rdata;
   logic                       div_start;
   logic                       div_done;
   logic [DATA_W-1:0]          div_quot;
   logic                       req_fire;
   logic                       can_step;
   logic signed [DATA_W:0]     dx_w, dq_w, dy_w, dy_neg;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rd        = point_type'(ram_rdata);
   assign ram_wdata = '{x: req_chan.point_x, y: req_chan.point_y};
   assign can_step  = ((CNT_W+1)'(seg_ff) + (CNT_W+1)'(2)) < (CNT_W+1)'(count_ff);
   assign dx_w      = {rd.x[DATA_W-1], rd.x} - {xl_ff[DATA_W-1], xl_ff};
   assign dq_w      = {qx_ff[DATA_W-1], qx_ff} - {xl_ff[DATA_W-1], xl_ff};
   assign dy_w      = {rd.y[DATA_W-1], rd.y} - {yl_ff[DATA_W-1], yl_ff};
   assign dy_neg    = -dy_w;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      seg_in       = seg_ff;
      qx_in        = qx_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      span_in      = span_ff;
      off_in       = off_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      below_in     = below_ff;
      none_in      = none_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_below_in = rsp_below_ff;
      rsp_none_in  = rsp_none_ff;
      ram_we       = 1'b0;
      ram_raddr    = seg_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     seg_in   = '0;
                  end
                  CMD_APPEND: begin
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_QUERY: begin
                     qx_in    = req_chan.query_x;
                     res_in   = '0;
                     below_in = 1'b0;
                     none_in  = 1'b0;
                     if (count_ff == '0) begin
                        none_in  = 1'b1;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_LEFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LEFT: begin
            xl_in = rd.x;
            yl_in = rd.y;
            if (qx_ff < rd.x) begin
               below_in = 1'b1;
               state_in = S_EMIT;
            end else if (count_ff == CNT_W'(1)) begin
               res_in   = rd.y;
               state_in = S_EMIT;
            end else begin
               ram_raddr = seg_ff + IDX_W'(1);
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (can_step && rd.x <= qx_ff) begin
               seg_in    = seg_ff + IDX_W'(1);
               xl_in     = rd.x;
               yl_in     = rd.y;
               ram_raddr = seg_ff + IDX_W'(2);
            end else if (qx_ff >= rd.x) begin
               res_in   = rd.y;
               state_in = S_EMIT;
            end else begin
               span_in  = dx_w[DATA_W-1:0];
               off_in   = dq_w[DATA_W-1:0];
               neg_in   = dy_w[DATA_W];
               mag_in   = dy_w[DATA_W] ? dy_neg[DATA_W-1:0] : dy_w[DATA_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = (2*DATA_W)'(mag_ff) * (2*DATA_W)'(off_ff);
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = neg_ff ? yl_ff - $signed(div_quot) : yl_ff + $signed(div_quot);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_below_in = below_ff;
               rsp_none_in  = none_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      qx_ff        <= qx_in;
      xl_ff        <= xl_in;
      yl_ff        <= yl_in;
      span_ff      <= span_in;
      off_ff       <= off_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      below_ff     <= below_in;
      none_ff      <= none_in;
      rsp_value_ff <= rsp_value_in;
      rsp_below_ff <= rsp_below_in;
      rsp_none_ff  <= rsp_none_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         seg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   plr_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_points (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   plr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_chan.ready       = state_ff == S_IDLE;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value       = rsp_value_ff;
   assign rsp_chan.below_range = rsp_below_ff;
   assign rsp_chan.no_table    = rsp_none_ff;

   `PLR_ASSERT_IMPLY(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POINTS), "point count past table size")
   `PLR_ASSERT_IMPLY(a_seg_bound, clock, reset, count_ff != '0, (CNT_W+1)'(seg_ff) < (CNT_W+1)'(count_ff), "segment pointer beyond table")
   `PLR_ASSERT_IMPLY(a_flag_excl, clock, reset, rsp_valid_ff, !(rsp_below_ff && rsp_none_ff), "both result flags set")
   `PLR_ASSERT_IMPLY(a_flag_zero, clock, reset, rsp_valid_ff && (rsp_below_ff || rsp_none_ff), rsp_value_ff == '0, "flagged result with nonzero value")

endmodule
